### rtl/core/bnfa_pkg.sv
`timescale 1ns / 1ps

package bnfa_pkg;

   // Default size of the slot pool.
   localparam int NUM_SLOTS_DEFAULT = 256;

   // Command codes carried in the cmd field of a request.
   localparam logic [1:0] CMD_ALLOC    = 2'd0;
   localparam logic [1:0] CMD_LOAD_MAP = 2'd1;
   localparam logic [1:0] CMD_LOAD_PTR = 2'd2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [4:0] byte_number;
      logic [7:0] byte_value;
      logic [7:0] start_slot;
   } alloc_req_type;

   typedef struct packed {
      logic [7:0] slot;
      logic       found;
   } alloc_rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic load_map;
      logic load_ptr;
      logic alloc_start;
      logic issue;
      logic finish;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic scan_done;
      logic issue_end;
   } dp_status_type;

endpackage

### rtl/core/bnfa_ctrl.sv
`timescale 1ns / 1ps

module bnfa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  bnfa_pkg::alloc_req_type req_data,
   input  bnfa_pkg::dp_status_type status,
   output bnfa_pkg::dp_cmd_type    cmd,
   output logic                   busy
);
   import bnfa_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               unique case (req_data.cmd)
                  CMD_ALLOC: begin
                     cmd.alloc_start = 1'b1;
                     state_in        = ST_SCAN;
                  end
                  CMD_LOAD_MAP: cmd.load_map = 1'b1;
                  CMD_LOAD_PTR: cmd.load_ptr = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // Keep fetching bytes until a verdict comes back.
            cmd.finish = status.scan_done;
            cmd.issue  = !status.scan_done && !status.issue_end;
            if (status.scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

### rtl/core/bnfa_datapath.sv
`timescale 1ns / 1ps

module bnfa_datapath #(
   parameter int NUM_SLOTS = bnfa_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bnfa_pkg::alloc_req_type  req_data,
   input  bnfa_pkg::dp_cmd_type     cmd,
   output bnfa_pkg::dp_status_type  status,
   output logic                    rsp_strobe,
   output bnfa_pkg::alloc_rsp_type  rsp_data
);
   import bnfa_pkg::*;

   localparam int BYTES  = (NUM_SLOTS + 7) / 8;
   localparam int ADDR_W = $clog2(BYTES);
   localparam int PTR_W  = $clog2(NUM_SLOTS);
   localparam int CNT_W  = $clog2(BYTES + 2);
   localparam int CMP_W  = ADDR_W + 4;

   localparam logic [ADDR_W-1:0] LAST_BYTE   = ADDR_W'(BYTES - 1);
   localparam logic [CNT_W-1:0]  CNT_LAST    = CNT_W'(BYTES);
   localparam logic [CNT_W-1:0]  CNT_END     = CNT_W'(BYTES + 1);
   localparam logic [CMP_W-1:0]  NUM_SLOTS_C = CMP_W'(NUM_SLOTS);

   logic [7:0] map_mem [BYTES];

   logic [ADDR_W-1:0] clear_cnt_ff, clear_cnt_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [ADDR_W-1:0] scan_addr_ff, scan_addr_in;
   logic [CNT_W-1:0]  issue_cnt_ff, issue_cnt_in;
   logic [7:0]        rdata_ff;
   logic              tag_valid_ff, tag_valid_in;
   logic              tag_first_ff, tag_first_in;
   logic              tag_last_ff, tag_last_in;
   logic [ADDR_W-1:0] tag_addr_ff, tag_addr_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   alloc_rsp_type     rsp_data_ff, rsp_data_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [7:0]        free_bits;
   logic [2:0]        hit_idx;
   logic              hit;
   logic [CMP_W-1:0]  hit_slot;
   logic [CMP_W-1:0]  next_ptr;
   logic [CMP_W-1:0]  ptr_ext;
   logic              map_in_range;

   assign ptr_ext      = CMP_W'(ptr_ff);
   assign map_in_range = int'(req_data.byte_number) < BYTES;

   // Slots of the fetched byte that take part in this pass of the scan.
   always_comb begin
      logic [CMP_W-1:0] s;
      logic             ok;
      for (int i = 0; i < 8; i++) begin
         s  = CMP_W'({tag_addr_ff, 3'(i)});
         ok = (s != '0) && (s < NUM_SLOTS_C);
         if (tag_first_ff && (s < ptr_ext)) ok = 1'b0;
         if (tag_last_ff && (s >= ptr_ext)) ok = 1'b0;
         free_bits[i] = ok && !rdata_ff[i];
      end
   end

   always_comb begin
      hit_idx = '0;
      for (int i = 7; i >= 0; i--) begin
         if (free_bits[i]) hit_idx = 3'(i);
      end
   end

   assign hit      = |free_bits;
   assign hit_slot = CMP_W'({tag_addr_ff, hit_idx});
   assign next_ptr = (hit_slot + CMP_W'(1) >= NUM_SLOTS_C) ? CMP_W'(1)
                                                          : hit_slot + CMP_W'(1);

   assign status.clear_last = clear_cnt_ff == LAST_BYTE;
   assign status.scan_done  = tag_valid_ff && (hit || tag_last_ff);
   assign status.issue_end  = issue_cnt_ff == CNT_END;

   // Single write port: clearing pass, byte load or allocation commit.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clear_cnt_ff;
      wr_data = '0;
      priority if (cmd.clear) begin
         wr_en = 1'b1;
      end else if (cmd.load_map) begin
         wr_en   = map_in_range;
         wr_addr = ADDR_W'(req_data.byte_number);
         wr_data = req_data.byte_value;
      end else if (cmd.finish) begin
         wr_en   = hit;
         wr_addr = tag_addr_ff;
         wr_data = rdata_ff | (8'd1 << hit_idx);
      end
   end

   always_comb begin
      clear_cnt_in  = cmd.clear ? clear_cnt_ff + ADDR_W'(1) : clear_cnt_ff;
      ptr_in        = ptr_ff;
      scan_addr_in  = scan_addr_ff;
      issue_cnt_in  = issue_cnt_ff;
      tag_valid_in  = cmd.issue;
      tag_first_in  = issue_cnt_ff == '0;
      tag_last_in   = issue_cnt_ff == CNT_LAST;
      tag_addr_in   = scan_addr_ff;
      rsp_strobe_in = cmd.finish;
      rsp_data_in   = rsp_data_ff;

      if (cmd.load_ptr) begin
         if (req_data.start_slot == 8'd0 || int'(req_data.start_slot) >= NUM_SLOTS) begin
            ptr_in = PTR_W'(1);
         end else begin
            ptr_in = PTR_W'(req_data.start_slot);
         end
      end
      if (cmd.alloc_start) begin
         scan_addr_in = ADDR_W'(ptr_ff >> 3);
         issue_cnt_in = '0;
      end
      if (cmd.issue) begin
         scan_addr_in = (scan_addr_ff == LAST_BYTE) ? '0 : scan_addr_ff + ADDR_W'(1);
         issue_cnt_in = issue_cnt_ff + CNT_W'(1);
      end
      if (cmd.finish) begin
         rsp_data_in.found = hit;
         rsp_data_in.slot  = hit ? 8'(hit_slot) : 8'd0;
         if (hit) begin
            ptr_in = PTR_W'(next_ptr);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (cmd.issue) begin
         rdata_ff <= map_mem[scan_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff  <= '0;
         ptr_ff        <= PTR_W'(1);
         issue_cnt_ff  <= '0;
         tag_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         clear_cnt_ff  <= clear_cnt_in;
         ptr_ff        <= ptr_in;
         issue_cnt_ff  <= issue_cnt_in;
         tag_valid_ff  <= tag_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      tag_first_ff <= tag_first_in;
      tag_last_ff  <= tag_last_in;
      tag_addr_ff  <= tag_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

### rtl/core/bitmap_next_fit_allocator_unit.sv
`timescale 1ns / 1ps

// Next-fit slot allocator over a used/free bitmap (bit set means used).
// A transfer is accepted when start is high and busy is low. An allocate
// command scans slots 1 to NUM_SLOTS-1 cyclically from the search pointer,
// one bitmap byte per cycle out of a single-port memory, marks the first
// free slot used and returns it, or returns found low when the pool is
// full; slot 0 is never handed out. Its result appears on rsp_data for
// exactly one cycle with rsp_strobe high, once the scan has read the bytes
// it needs (NUM_SLOTS/8 + 1 reads when the pool is full).
// The receiver cannot stall: it must take the result in that cycle. Load
// commands (bitmap byte, search pointer) and unknown commands finish in
// the cycle of acceptance, return no result and leave busy low. After
// reset a clearing pass writes zeros to every bitmap byte, one byte per
// cycle, and busy stays high until it is done.

module bitmap_next_fit_allocator_unit #(
   parameter int NUM_SLOTS = bnfa_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  bnfa_pkg::alloc_req_type req_data,
   output logic                   rsp_strobe,
   output bnfa_pkg::alloc_rsp_type rsp_data
);
   import bnfa_pkg::*;

   // Controller and datapath talk only through these two bundles.
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // The controller sequences the clearing pass, decodes commands and
   // steps the byte scan until the datapath reports a hit or a full pool.
   bnfa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .status   (dp_status),
      .cmd      (dp_cmd),
      .busy     (busy)
   );

   // The datapath holds the bitmap memory, the search pointer, the scan
   // address and the registered result.
   bnfa_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (dp_cmd),
      .status     (dp_status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
